// ===== rtl/pfde_pkg.sv =====
// Shared types and codes for the paged framebuffer draw engine.
`timescale 1ns / 1ps
package pfde_pkg;

  typedef enum logic [2:0] {
    CMD_PIXEL = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_RECT  = 3'd2,
    CMD_FILL  = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_LINE_SETUP,
    ST_LINE_RD,
    ST_LINE_WAIT,
    ST_LINE_WR,
    ST_FILL_RD,
    ST_FILL_WAIT,
    ST_FILL_WR,
    ST_SCREEN,
    ST_READ_WAIT,
    ST_READ_OUT,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       capture;     // latch the command fields
    logic       init_clear;  // sweep zeros after reset
    logic       line_setup;  // load a line from the segment counter
    logic       line_step;   // advance the Bresenham walker
    logic       fill_init;   // load fill counters
    logic       fill_step;   // advance fill counters
    logic       screen_step; // write one byte of a full-screen fill
    logic       mem_read;    // read the current pixel byte
    logic       mem_write;   // write back the modified byte
    logic       read_req;    // read for a read command
    logic       out_latch;   // take read data into the output
    logic       result;      // present the result
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic       sweep_last;  // last byte of a sweep
    logic       line_last;   // segment walker done with final pixel
    logic       seg_last;    // last segment of the command
    logic       fill_last;   // fill counters at final pixel
    logic       fill_bad;    // reversed corners or off-screen first corner
    logic [2:0] cmd;
  } sts_t;

endpackage

// ===== rtl/pfde_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// ===== rtl/pfde_datapath.sv =====
// Datapath: coordinate walkers, address generation and framebuffer store.
`timescale 1ns / 1ps
module pfde_datapath import pfde_pkg::*; #(
  parameter int DISP_COLS = 128,
  parameter int DISP_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_t       ctl,
  output sts_t       sts,
  input  logic [2:0] in_command,
  input  logic [7:0] in_x_first,
  input  logic [7:0] in_y_first,
  input  logic [7:0] in_x_second,
  input  logic [7:0] in_y_second,
  input  logic       in_ink,
  input  logic [9:0] in_byte_index,
  output logic [7:0] out_read_data,
  output logic       out_ignored
);

  localparam int PAGES = (DISP_ROWS + 7) / 8;
  localparam int STORE = DISP_COLS * PAGES;
  localparam int AW    = $clog2(STORE);

  logic [2:0] cmd_r;
  logic [7:0] x1_r, y1_r, x2_r, y2_r;
  logic       ink_r;
  logic [9:0] bidx_r;
  logic [1:0] seg_r;

  logic signed [9:0]  ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic signed [1:0]  sx_r, sy_r;
  logic signed [11:0] err_r;
  logic               first_r;
  logic [8:0]         fi_r, fj_r;
  logic [AW-1:0]      sweep_r;
  logic [7:0]         rd_r;
  logic               ign_r;

  logic [7:0] sax, say, sbx, sby;
  logic signed [9:0] px, py;
  logic [AW-1:0] addr;
  logic          we;
  logic [7:0]    wdata, rdata, bitm;
  logic          pix_on;
  logic signed [12:0] e2;
  logic [9:0] pxu, pyu;
  logic [AW+8:0] full_idx;
  logic [9:0] ndx, ndy;

  function automatic logic [7:0] in_ink_sel(input logic k, input logic [7:0] d,
                                             input logic [7:0] m);
    return k ? (d | m) : (d & ~m);
  endfunction

  always_comb begin
    sax = x1_r; say = y1_r; sbx = x2_r; sby = y2_r;
    if (cmd_r == CMD_PIXEL) begin
      sbx = x1_r;
      sby = y1_r;
    end else if (cmd_r == CMD_RECT) begin
      unique case (seg_r)
        2'd0: begin sax = x1_r; say = y1_r; sbx = x2_r; sby = y1_r; end
        2'd1: begin sax = x2_r; say = y1_r; sbx = x2_r; sby = y2_r; end
        2'd2: begin sax = x2_r; say = y2_r; sbx = x1_r; sby = y2_r; end
        default: begin sax = x1_r; say = y2_r; sbx = x1_r; sby = y1_r; end
      endcase
    end
  end

  assign ndx = (sbx > sax) ? {2'b0, sbx - sax} : {2'b0, sax - sbx};
  assign ndy = (sby > say) ? {2'b0, sby - say} : {2'b0, say - sby};

  always_comb begin
    if (cmd_r == CMD_FILL) begin
      px = $signed({1'b0, fi_r});
      py = $signed({1'b0, fj_r});
    end else if (first_r) begin
      px = bx_r;
      py = by_r;
    end else begin
      px = ax_r;
      py = ay_r;
    end
  end

  assign pxu    = px;
  assign pyu    = py;
  assign pix_on = !px[9] && !py[9] && (pxu < 10'(DISP_COLS)) &&
                  (pyu < 10'(DISP_ROWS));
  assign full_idx = (AW + 9)'(pxu) + (AW + 9)'(pyu >> 3) * (AW + 9)'(DISP_COLS);
  assign bitm   = 8'(1) << pyu[2:0];
  assign e2     = {err_r, 1'b0};

  always_comb begin
    addr  = full_idx[AW-1:0];
    we    = 1'b0;
    wdata = in_ink_sel(ink_r, rdata, bitm);
    if (ctl.init_clear || ctl.screen_step) begin
      addr  = sweep_r;
      we    = 1'b1;
      wdata = (ctl.screen_step && ink_r) ? 8'hFF : 8'h00;
    end else if (ctl.read_req) begin
      addr = AW'(bidx_r);
    end else if (ctl.mem_write) begin
      we = pix_on;
    end
  end

  pfde_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      seg_r   <= '0;
      rd_r    <= '0;
      ign_r   <= 1'b0;
      out_read_data <= '0;
      out_ignored   <= 1'b0;
    end else begin
      if (ctl.capture) begin
        cmd_r  <= in_command;
        x1_r   <= in_x_first;
        y1_r   <= in_y_first;
        x2_r   <= in_x_second;
        y2_r   <= in_y_second;
        ink_r  <= in_ink;
        bidx_r <= in_byte_index;
        seg_r  <= '0;
        sweep_r <= '0;
        rd_r   <= '0;
        ign_r  <= 1'b0;
      end
      if (ctl.init_clear || ctl.screen_step) begin
        sweep_r <= (sweep_r == AW'(STORE - 1)) ? '0 : sweep_r + 1'b1;
      end
      if (ctl.line_setup) begin
        ax_r <= {2'b0, sax};
        ay_r <= {2'b0, say};
        bx_r <= {2'b0, sbx};
        by_r <= {2'b0, sby};
        dx_r <= ndx;
        dy_r <= ndy;
        sx_r <= (sax < sbx) ? 2'sd1 : -2'sd1;
        sy_r <= (say < sby) ? 2'sd1 : -2'sd1;
        err_r <= 12'($signed({2'b0, ndx}) - $signed({2'b0, ndy}));
        first_r <= 1'b1;
      end
      if (ctl.line_step) begin
        if (first_r) begin
          first_r <= 1'b0;
        end else begin
          if (e2 > -13'(dy_r) && e2 < 13'(dx_r)) begin
            err_r <= err_r - 12'(dy_r) + 12'(dx_r);
          end else if (e2 > -13'(dy_r)) begin
            err_r <= err_r - 12'(dy_r);
          end else if (e2 < 13'(dx_r)) begin
            err_r <= err_r + 12'(dx_r);
          end
          if (e2 > -13'(dy_r)) ax_r <= ax_r + 10'(sx_r);
          if (e2 < 13'(dx_r))  ay_r <= ay_r + 10'(sy_r);
        end
        if (sts.line_last) seg_r <= seg_r + 1'b1;
      end
      if (ctl.fill_init) begin
        fi_r <= {1'b0, x1_r};
        fj_r <= {1'b0, y1_r};
        ign_r <= (x1_r > x2_r) || (y1_r > y2_r);
      end
      if (ctl.fill_step) begin
        if (fj_r >= {1'b0, y2_r} || fj_r >= 9'(DISP_ROWS - 1)) begin
          fj_r <= {1'b0, y1_r};
          fi_r <= fi_r + 1'b1;
        end else begin
          fj_r <= fj_r + 1'b1;
        end
      end
      if (ctl.out_latch) begin
        rd_r <= ({2'b00, bidx_r} < 12'(STORE)) ? rdata : 8'h00;
      end
      if (ctl.result) begin
        out_read_data <= rd_r;
        out_ignored   <= ign_r;
      end
    end
  end

  always_comb begin
    sts.sweep_last = (sweep_r == AW'(STORE - 1));
    sts.line_last  = first_r ? ((ax_r == bx_r) && (ay_r == by_r)) :
                     ((ax_r + ((e2 > -13'(dy_r)) ? 10'(sx_r) : 10'd0)) == bx_r &&
                      (ay_r + ((e2 < 13'(dx_r)) ? 10'(sy_r) : 10'd0)) == by_r);
    sts.seg_last   = (cmd_r != CMD_RECT) || (seg_r == 2'd3);
    sts.fill_last  = (fj_r >= {1'b0, y2_r} || fj_r >= 9'(DISP_ROWS - 1)) &&
                     (fi_r >= {1'b0, x2_r} || fi_r >= 9'(DISP_COLS - 1));
    sts.fill_bad   = (x1_r > x2_r) || (y1_r > y2_r) ||
                     (x1_r >= 8'(DISP_COLS)) || ({1'b0, y1_r} >= 9'(DISP_ROWS));
    sts.cmd        = cmd_r;
  end

endmodule

// ===== rtl/pfde_ctrl.sv =====
// Controller state machine for the draw engine.
`timescale 1ns / 1ps
module pfde_ctrl import pfde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_DONE);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:       if (sts.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:       if (start) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (sts.cmd) inside
          CMD_PIXEL, CMD_LINE, CMD_RECT: state_nxt = ST_LINE_SETUP;
          CMD_FILL:  state_nxt = ST_FILL_RD;
          CMD_CLEAR: state_nxt = ST_SCREEN;
          CMD_READ:  state_nxt = ST_READ_WAIT;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_LINE_SETUP: state_nxt = ST_LINE_RD;
      ST_LINE_RD:    state_nxt = ST_LINE_WAIT;
      ST_LINE_WAIT:  state_nxt = ST_LINE_WR;
      ST_LINE_WR: begin
        if (sts.cmd == CMD_PIXEL) state_nxt = ST_DONE;
        else if (!sts.line_last) state_nxt = ST_LINE_RD;
        else if (sts.seg_last) state_nxt = ST_DONE;
        else state_nxt = ST_LINE_SETUP;
      end
      ST_FILL_RD:    state_nxt = sts.fill_bad ? ST_DONE : ST_FILL_WAIT;
      ST_FILL_WAIT:  state_nxt = ST_FILL_WR;
      ST_FILL_WR:    state_nxt = sts.fill_last ? ST_DONE : ST_FILL_RD;
      ST_SCREEN:     if (sts.sweep_last) state_nxt = ST_DONE;
      ST_READ_WAIT:  state_nxt = ST_READ_OUT;
      ST_READ_OUT:   state_nxt = ST_DONE;
      ST_DONE:       state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_INIT:       ctl.init_clear = 1'b1;
      ST_IDLE:       ctl.capture = start;
      ST_DECODE:     ctl.fill_init = (sts.cmd == CMD_FILL);
      ST_LINE_SETUP: ctl.line_setup = 1'b1;
      ST_LINE_RD:    ctl.mem_read = 1'b1;
      ST_LINE_WR: begin
        ctl.mem_write = 1'b1;
        ctl.line_step = 1'b1;
      end
      ST_FILL_RD:    ctl.mem_read = 1'b1;
      ST_FILL_WR: begin
        ctl.mem_write = 1'b1;
        ctl.fill_step = 1'b1;
      end
      ST_SCREEN:     ctl.screen_step = 1'b1;
      ST_READ_WAIT:  ctl.read_req = 1'b1;
      ST_READ_OUT: begin
        ctl.read_req  = 1'b1;
        ctl.out_latch = 1'b1;
      end
      ST_DONE:       ctl.result = 1'b1;
      default:       ctl = '0;
    endcase
  end

endmodule

// ===== rtl/page_framebuffer_draw_engine.sv =====
// Top level of the paged monochrome framebuffer draw engine.
// Channel  Handshake             Fields
// in       start / busy          command x_first y_first x_second y_second ink byte_index
// out      out_valid (strobe)    read_data ignored
// Every item: a decode state, the work below, a done state; the strobe follows done.
// Pixel: a setup state, then read, wait and write; line: setup, then read, wait, write per pixel.
// Rectangle fill: read, wait, write per on-screen pixel, a bad fill ends after read; outline: 4 lines;
// fill screen one per byte. Read byte passes a wait state and an output state between decode and done.
// After reset a clearing pass that writes one framebuffer byte per cycle holds busy high.
// Results cannot be stalled.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine import pfde_pkg::*; #(
  parameter int DISP_COLS = 128,
  parameter int DISP_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [7:0] in_x_first,
  input  logic [7:0] in_y_first,
  input  logic [7:0] in_x_second,
  input  logic [7:0] in_y_second,
  input  logic       in_ink,
  input  logic [9:0] in_byte_index,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_ignored
);

  ctl_t ctl;
  sts_t sts;

  pfde_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .sts(sts), .ctl(ctl)
  );

  pfde_datapath #(
    .DISP_COLS(DISP_COLS), .DISP_ROWS(DISP_ROWS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_command(in_command), .in_x_first(in_x_first), .in_y_first(in_y_first),
    .in_x_second(in_x_second), .in_y_second(in_y_second), .in_ink(in_ink),
    .in_byte_index(in_byte_index),
    .out_read_data(out_read_data), .out_ignored(out_ignored)
  );

endmodule

// ===== verif/page_framebuffer_draw_engine_test.sv =====
// Self-checking testbench for the paged framebuffer draw engine.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_test import pfde_pkg::*;;

  localparam int SCR_W = 128;
  localparam int SCR_H = 64;
  localparam int STORE_SIZE = SCR_W * ((SCR_H + 7) / 8);
  localparam int STALL_LIMIT = 200000;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_second;
    logic [7:0] y_second;
    logic       ink;
    logic [9:0] byte_index;
  } draw_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ignored;
  } draw_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_command = '0;
  logic [7:0] in_x_first = '0;
  logic [7:0] in_y_first = '0;
  logic [7:0] in_x_second = '0;
  logic [7:0] in_y_second = '0;
  logic       in_ink = 1'b0;
  logic [9:0] in_byte_index = '0;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_ignored;

  logic [7:0]   shadow_frame [STORE_SIZE];
  draw_result_t expected_results [$];
  int           idle_cycles = 0;
  bit           failed = 1'b0;
  int           burst_left = 0;

  page_framebuffer_draw_engine #(.DISP_COLS(SCR_W), .DISP_ROWS(SCR_H)) uut (
    .clk, .rst_n, .start, .busy, .in_command, .in_x_first, .in_y_first, .in_x_second,
    .in_y_second, .in_ink, .in_byte_index, .out_valid, .out_read_data, .out_ignored
  );

  always #5 clk = ~clk;

  function automatic void plot(int x, int y, logic ink);
    int idx;
    if (x < 0 || y < 0 || x >= SCR_W || y >= SCR_H) return;
    idx = x + (y / 8) * SCR_W;
    if (ink) shadow_frame[idx][y % 8] = 1'b1;
    else shadow_frame[idx][y % 8] = 1'b0;
  endfunction

  function automatic void trace_line(int ax, int ay, int bx, int by, logic ink);
    int dx, dy, sx, sy, err, e2;
    dx = (bx > ax) ? bx - ax : ax - bx;
    dy = (by > ay) ? by - ay : ay - by;
    sx = (ax < bx) ? 1 : -1;
    sy = (ay < by) ? 1 : -1;
    err = dx - dy;
    plot(bx, by, ink);
    while (ax != bx || ay != by) begin
      plot(ax, ay, ink);
      e2 = err * 2;
      if (e2 > -dy) begin
        err -= dy;
        ax += sx;
      end
      if (e2 < dx) begin
        err += dx;
        ay += sy;
      end
    end
  endfunction

  function automatic draw_result_t apply_draw(draw_item_t it);
    draw_result_t r;
    int x1, y1, x2, y2;
    r = '0;
    x1 = it.x_first;
    y1 = it.y_first;
    x2 = it.x_second;
    y2 = it.y_second;
    case (it.command)
      CMD_PIXEL: plot(x1, y1, it.ink);
      CMD_LINE: trace_line(x1, y1, x2, y2, it.ink);
      CMD_RECT: begin
        trace_line(x1, y1, x2, y1, it.ink);
        trace_line(x2, y1, x2, y2, it.ink);
        trace_line(x2, y2, x1, y2, it.ink);
        trace_line(x1, y2, x1, y1, it.ink);
      end
      CMD_FILL: begin
        if (x1 > x2 || y1 > y2) r.ignored = 1'b1;
        else
          for (int i = x1; i <= x2 && i < SCR_W; i++)
            for (int j = y1; j <= y2 && j < SCR_H; j++) plot(i, j, it.ink);
      end
      CMD_CLEAR: foreach (shadow_frame[k]) shadow_frame[k] = it.ink ? 8'hFF : 8'h00;
      CMD_READ: if (it.byte_index < STORE_SIZE) r.read_data = shadow_frame[it.byte_index];
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(draw_item_t it);
    start <= 1'b1;
    in_command <= it.command;
    in_x_first <= it.x_first;
    in_y_first <= it.y_first;
    in_x_second <= it.x_second;
    in_y_second <= it.y_second;
    in_ink <= it.ink;
    in_byte_index <= it.byte_index;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_draw(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic draw_item_t make_item(logic [2:0] cmd, int x1, int y1, int x2, int y2,
                                           logic ink, int bidx);
    draw_item_t it;
    it.command = cmd;
    it.x_first = 8'(x1);
    it.y_first = 8'(y1);
    it.x_second = 8'(x2);
    it.y_second = 8'(y2);
    it.ink = ink;
    it.byte_index = 10'(bidx);
    return it;
  endfunction

  function automatic int pick_coord(int span);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span + 8);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item pending: read_data %h ignored %b", $time,
                 out_read_data, out_ignored);
        failed = 1'b1;
      end else begin
        draw_result_t want;
        want = expected_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   out_read_data);
          failed = 1'b1;
        end
        if (out_ignored !== want.ignored) begin
          $display("%0t: ignored expected %b actual %b", $time, want.ignored, out_ignored);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("page_framebuffer_draw_engine verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 0));
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 1023));
    send_item(make_item(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0));
    send_item(make_item(CMD_PIXEL, 127, 63, 0, 0, 1'b1, 0));
    send_item(make_item(CMD_PIXEL, 128, 64, 0, 0, 1'b1, 0));
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 1023));
    send_item(make_item(CMD_LINE, 0, 0, 127, 63, 1'b1, 0));
    send_item(make_item(CMD_LINE, 255, 255, 100, 10, 1'b1, 0));
    send_item(make_item(CMD_LINE, 5, 60, 5, 60, 1'b0, 0));
    send_item(make_item(CMD_RECT, 120, 50, 200, 255, 1'b1, 0));
    send_item(make_item(CMD_RECT, 10, 10, 3, 2, 1'b1, 0));
    send_item(make_item(CMD_FILL, 20, 5, 10, 8, 1'b1, 0));
    send_item(make_item(CMD_FILL, 20, 8, 30, 3, 1'b1, 0));
    send_item(make_item(CMD_FILL, 120, 60, 255, 255, 1'b1, 0));
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 1023));
    send_item(make_item(CMD_FILL, 0, 0, 255, 255, 1'b0, 0));
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 512));
    send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 1'b1, 0));
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 341));
    send_item(make_item(CMD_SPARE6, 255, 255, 255, 255, 1'b1, 1023));
    send_item(make_item(CMD_SPARE7, 1, 1, 1, 1, 1'b0, 682));
    send_item(make_item(CMD_PIXEL, 64, 33, 0, 0, 1'b0, 0));
    send_item(make_item(CMD_READ, 0, 0, 0, 0, 1'b0, 64 + 4 * SCR_W));
    send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0));
  endtask

  task automatic test_random(int count);
    draw_item_t it;
    int sel, w, h;
    repeat (count) begin
      it = '0;
      it.ink = 1'($urandom_range(0, 1));
      it.byte_index = 10'($urandom_range(0, 1023));
      it.x_first = 8'(pick_coord(SCR_W));
      it.y_first = 8'(pick_coord(SCR_H));
      it.x_second = 8'(pick_coord(SCR_W));
      it.y_second = 8'(pick_coord(SCR_H));
      sel = $urandom_range(0, 99);
      if (sel < 22) it.command = CMD_PIXEL;
      else if (sel < 37) it.command = CMD_LINE;
      else if (sel < 45) it.command = CMD_RECT;
      else if (sel < 56) begin
        it.command = CMD_FILL;
        if ($urandom_range(0, 19) != 0) begin
          w = $urandom_range(0, 7);
          h = $urandom_range(0, 9);
          it.x_second = 8'((it.x_first + w > 255) ? 255 : it.x_first + w);
          it.y_second = 8'((it.y_first + h > 255) ? 255 : it.y_first + h);
          if ($urandom_range(0, 5) == 0) it.x_first = it.x_second + 8'd1;
          if ($urandom_range(0, 5) == 0) it.y_first = it.y_second + 8'd1;
        end
      end else if (sel < 58) it.command = CMD_CLEAR;
      else if (sel < 95) it.command = CMD_READ;
      else it.command = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
      send_item(it);
    end
  endtask

  initial begin
    foreach (shadow_frame[k]) shadow_frame[k] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1400);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("page_framebuffer_draw_engine verification clean");
    end else begin
      $display("page_framebuffer_draw_engine verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pfde_pkg.sv
rtl/pfde_ram.sv
rtl/pfde_datapath.sv
rtl/pfde_ctrl.sv
rtl/page_framebuffer_draw_engine.sv
verif/page_framebuffer_draw_engine_test.sv
